// ===== hdl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and request codes for the lru key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam logic [1:0] REQ_GET  = 2'd0;
	localparam logic [1:0] REQ_PUT  = 2'd1;
	localparam logic [1:0] REQ_DEL  = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_UNLINK,
		ST_LINK,
		ST_DONE
	} back_state_t;

endpackage

// ===== hdl/lkvc_front.sv =====
// ----------------------------------------------------------------------------
// lkvc_front
// Two-entry queue towards the back end.
// ----------------------------------------------------------------------------
module lkvc_front #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            in_req,
	input  logic [KEY_BITS-1:0]   in_key,
	input  logic [VALUE_BITS-1:0] in_value,
	output logic                  q_valid,
	input  logic                  q_pop,
	output logic [1:0]            q_req,
	output logic [KEY_BITS-1:0]   q_key,
	output logic [VALUE_BITS-1:0] q_value
);
	import lkvc_pkg::*;

	localparam int W = 2 + KEY_BITS + VALUE_BITS;

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign {q_req, q_key, q_value} = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {in_req, in_key, in_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== hdl/lkvc_back.sv =====
// ----------------------------------------------------------------------------
// lkvc_back
// Slot store, key match and linked-list updates; one request at a time.
// ----------------------------------------------------------------------------
module lkvc_back #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  logic [1:0]            q_req,
	input  logic [KEY_BITS-1:0]   q_key,
	input  logic [VALUE_BITS-1:0] q_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value
);
	import lkvc_pkg::*;

	localparam int LW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);
	localparam logic [LW-1:0] NONE = LW'(ENTRIES);

	back_state_t state_q, state_d;

	logic [KEY_BITS-1:0]   keys_q   [ENTRIES];
	logic [VALUE_BITS-1:0] values_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [LW-1:0]         prev_q   [ENTRIES];
	logic [LW-1:0]         next_q   [ENTRIES];
	logic [LW-1:0]         head_q, tail_q, free_q, slots_q;

	logic [1:0]            req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic                  hit_q;
	logic [IW-1:0]         slot_q;
	logic                  act_q;
	logic                  link_q;

	logic [ENTRIES-1:0]    match;
	logic                  found;
	logic [IW-1:0]         found_idx;
	logic [LW-1:0]         slots_n;
	logic                  apply_ok, promote_d, evict_d, fill_d;

	always_comb begin
		match = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key_q) && (LW'(i) < slots_q);
		end
	end

	always_comb begin
		found_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) found_idx = IW'(i);
		end
	end

	assign found = |match;
	assign slots_n = (32'(cfg_wdata) > 32'(ENTRIES)) ? NONE : LW'(cfg_wdata);

	assign apply_ok  = (slots_q != '0) && (req_q != REQ_NONE);
	assign promote_d = found && (req_q != REQ_DEL) && (LW'(found_idx) != head_q);
	assign evict_d   = !found && (req_q == REQ_PUT) && (free_q == NONE) && (tail_q != NONE);
	assign fill_d    = !found && (req_q == REQ_PUT) && ((free_q != NONE) || (tail_q != NONE));

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) state_d = ST_APPLY;
			end
			ST_APPLY:  state_d = ST_UNLINK;
			ST_UNLINK: state_d = ST_LINK;
			ST_LINK:   state_d = ST_DONE;
			ST_DONE:   if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign out_valid  = (state_q == ST_DONE);
	assign hit        = hit_q;
	assign read_value = (hit_q && req_q == REQ_GET) ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
			key_q <= q_key;
			val_q <= q_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= NONE;
			tail_q  <= NONE;
			free_q  <= '0;
			slots_q <= NONE;
			hit_q   <= 1'b0;
			act_q   <= 1'b0;
			link_q  <= 1'b0;
			slot_q  <= '0;
			rdata_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				prev_q[i] <= NONE;
				next_q[i] <= (i + 1 < ENTRIES) ? LW'(i + 1) : NONE;
			end
		end else if (cfg_we) begin
			valid_q <= '0;
			head_q  <= NONE;
			tail_q  <= NONE;
			slots_q <= slots_n;
			free_q  <= (slots_n != '0) ? '0 : NONE;
			for (int i = 0; i < ENTRIES; i++) begin
				prev_q[i] <= NONE;
				next_q[i] <= (LW'(i + 1) < slots_n) ? LW'(i + 1) : NONE;
			end
		end else begin
			unique case (state_q)
				ST_APPLY: begin
					hit_q  <= apply_ok && found;
					act_q  <= apply_ok && (promote_d || (found && req_q == REQ_DEL) || evict_d);
					link_q <= apply_ok && (promote_d || fill_d);
					if (apply_ok) begin
						if (found) begin
							slot_q <= found_idx;
							if (req_q == REQ_GET) begin
								rdata_q <= values_q[found_idx];
							end else if (req_q == REQ_PUT) begin
								values_q[found_idx] <= val_q;
							end else begin
								valid_q[found_idx] <= 1'b0;
							end
						end else if (req_q == REQ_PUT) begin
							if (free_q != NONE) begin
								slot_q <= free_q[IW-1:0];
								free_q <= next_q[free_q[IW-1:0]];
								keys_q[free_q[IW-1:0]]   <= key_q;
								values_q[free_q[IW-1:0]] <= val_q;
								valid_q[free_q[IW-1:0]]  <= 1'b1;
							end else if (tail_q != NONE) begin
								slot_q <= tail_q[IW-1:0];
								keys_q[tail_q[IW-1:0]]   <= key_q;
								values_q[tail_q[IW-1:0]] <= val_q;
								valid_q[tail_q[IW-1:0]]  <= 1'b1;
							end
						end
					end
				end
				ST_UNLINK: begin
					if (act_q) begin
						if (prev_q[slot_q] != NONE) next_q[prev_q[slot_q][IW-1:0]] <= next_q[slot_q];
						else head_q <= next_q[slot_q];
						if (next_q[slot_q] != NONE) prev_q[next_q[slot_q][IW-1:0]] <= prev_q[slot_q];
						else tail_q <= prev_q[slot_q];
						prev_q[slot_q] <= NONE;
						if (!link_q) begin
							next_q[slot_q] <= free_q;
							free_q <= LW'(slot_q);
						end else begin
							next_q[slot_q] <= NONE;
						end
					end
				end
				ST_LINK: begin
					if (link_q) begin
						prev_q[slot_q] <= NONE;
						next_q[slot_q] <= head_q;
						if (head_q != NONE) prev_q[head_q[IW-1:0]] <= LW'(slot_q);
						head_q <= LW'(slot_q);
						if (tail_q == NONE) tail_q <= LW'(slot_q);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fixed-capacity key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests (req_type get, put or delete, key, write_value) arrive on the
// input channel by valid/stall; every request gives one result transfer
// (hit, read_value) on the output channel.
// A front queue of two entries takes requests while the back end works.
// The back end takes the request, then does key match and data update,
// then unlinks the slot from the recency list and links it at the front,
// then holds the result; it takes the next request only after the result
// is taken.
// While the output is stalled the result holds and the back end waits;
// the front queue keeps taking requests until it is full.
// Reset leaves capacity 16, every slot free and the recency list empty.
// Writing capacity (0 to 16, larger values saturate) empties the store;
// write it only while no request is in flight.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] write_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value
);
	import lkvc_pkg::*;

	logic                  q_valid, q_pop;
	logic [1:0]            q_req;
	logic [KEY_BITS-1:0]   q_key;
	logic [VALUE_BITS-1:0] q_value;

	lkvc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_req(req_type), .in_key(key), .in_value(write_value),
		.q_valid, .q_pop, .q_req, .q_key, .q_value
	);

	lkvc_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.q_valid, .q_pop, .q_req, .q_key, .q_value,
		.out_valid, .out_stall, .hit, .read_value
	);

endmodule
